/* design/rgbgrad_pkg.sv */
// ----------------------------------------------------------------------------
// RGB565 gradient generator package
// Shared widths, register indexes, configuration struct and colour helpers
// for the gradient pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbgrad_pkg;

  // Default configuration of the display and the stop bank.
  localparam int DEF_DISPLAY_WIDTH  = 240;
  localparam int DEF_DISPLAY_HEIGHT = 135;
  localparam int DEF_MAX_STOPS      = 4;

  // Payload widths.
  localparam int COORD_W = 8;
  localparam int COLOR_W = 16;

  // Colour channel layout: red 15..11, green 10..5, blue 4..0.
  localparam int RB_W      = 5;
  localparam int G_W       = 6;
  localparam int RED_LSB   = 11;
  localparam int GREEN_LSB = 5;
  localparam int BLUE_LSB  = 0;
  localparam int CHAN_W    = 6;
  localparam int NUM_CHANS = 3;
  localparam int CH_RED    = 2;
  localparam int CH_GREEN  = 1;
  localparam int CH_BLUE   = 0;

  // Segment arithmetic: segment count is at most seven.
  localparam int SEG_W    = 3;
  localparam int NSTOPS_W = 3;
  localparam int NUM_W    = COORD_W + SEG_W;

  // Divider: quotient bits resolved per stage and the resulting depth.
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = CHAN_W / DIV_BITS;
  localparam int PIPE_DEPTH = 3 + DIV_STAGES;

  // Register port.
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int REG_IDX_W     = 3;
  localparam int NUM_STOP_REGS = 4;
  localparam logic [REG_IDX_W-1:0] REG_NUM_STOPS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_VERTICAL  = 3'd5;

  // Settings seen by the pipeline.
  typedef struct packed {
    logic [SEG_W-1:0] seg_count;
    logic             vertical;
  } cfg_t;

  typedef logic [NUM_CHANS-1:0][CHAN_W-1:0] chans_t;

  // Split an RGB565 word into three zero-extended channels.
  function automatic chans_t split565(input logic [COLOR_W-1:0] color);
    chans_t ch;
    ch[CH_RED]   = CHAN_W'(color[RED_LSB +: RB_W]);
    ch[CH_GREEN] = CHAN_W'(color[GREEN_LSB +: G_W]);
    ch[CH_BLUE]  = CHAN_W'(color[BLUE_LSB +: RB_W]);
    return ch;
  endfunction

  // Pack three channels back into an RGB565 word.
  function automatic logic [COLOR_W-1:0] join565(input chans_t ch);
    return {ch[CH_RED][RB_W-1:0], ch[CH_GREEN][G_W-1:0], ch[CH_BLUE][RB_W-1:0]};
  endfunction

endpackage

`default_nettype wire

/* design/rgbgrad_regs.sv */
// ----------------------------------------------------------------------------
// RGB565 gradient register bank
// APB-style register file holding the colour stops, the stop count and the
// axis select, with the clamped settings handed to the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbgrad_regs #(
  parameter int MAX_STOPS = rgbgrad_pkg::DEF_MAX_STOPS
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            psel,
  input  logic                                            penable,
  input  logic                                            pwrite,
  input  logic [rgbgrad_pkg::ADDR_W-1:0]                  paddr,
  input  logic [rgbgrad_pkg::DATA_W-1:0]                  pwdata,
  output logic [rgbgrad_pkg::DATA_W-1:0]                  prdata,
  output logic                                            pready,
  output logic [MAX_STOPS-1:0][rgbgrad_pkg::COLOR_W-1:0]  stop_color,
  output rgbgrad_pkg::cfg_t                               cfg
);

  localparam int NCMP_W = rgbgrad_pkg::NSTOPS_W + 1;
  localparam logic [NCMP_W-1:0] MAX_N = NCMP_W'(MAX_STOPS);

  logic [rgbgrad_pkg::NSTOPS_W-1:0]  num_stops;
  logic                              vertical_mode;
  logic [rgbgrad_pkg::REG_IDX_W-1:0] reg_idx;
  logic                              wr_en;
  logic [rgbgrad_pkg::DATA_W-1:0]    prdata_next;
  logic [NCMP_W-1:0]                 n_eff;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign reg_idx = paddr[rgbgrad_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_color    <= '0;
      num_stops     <= rgbgrad_pkg::NSTOPS_W'(1);
      vertical_mode <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        rgbgrad_pkg::REG_NUM_STOPS: begin
          num_stops <= pwdata[rgbgrad_pkg::NSTOPS_W-1:0];
        end
        rgbgrad_pkg::REG_VERTICAL: begin
          vertical_mode <= pwdata[0];
        end
        default: begin
          for (int i = 0; i < MAX_STOPS; i++) begin
            if (i < rgbgrad_pkg::NUM_STOP_REGS &&
                reg_idx == rgbgrad_pkg::REG_IDX_W'(i)) begin
              stop_color[i] <= pwdata[rgbgrad_pkg::COLOR_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // Read data is fetched in the setup cycle and shown in the access cycle.
  always_comb begin
    prdata_next = '0;
    case (reg_idx)
      rgbgrad_pkg::REG_NUM_STOPS: begin
        prdata_next = rgbgrad_pkg::DATA_W'(num_stops);
      end
      rgbgrad_pkg::REG_VERTICAL: begin
        prdata_next = rgbgrad_pkg::DATA_W'(vertical_mode);
      end
      default: begin
        for (int i = 0; i < MAX_STOPS; i++) begin
          if (i < rgbgrad_pkg::NUM_STOP_REGS &&
              reg_idx == rgbgrad_pkg::REG_IDX_W'(i)) begin
            prdata_next = rgbgrad_pkg::DATA_W'(stop_color[i]);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prdata <= '0;
    end else if (psel && !penable) begin
      prdata <= prdata_next;
    end
  end

  // Clamp the stop count to one up to the size of the stop bank.
  always_comb begin
    if (num_stops == '0) begin
      n_eff = NCMP_W'(1);
    end else if ({1'b0, num_stops} > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = {1'b0, num_stops};
    end
    cfg.seg_count = rgbgrad_pkg::SEG_W'(n_eff - 1'b1);
    cfg.vertical  = vertical_mode;
  end

endmodule

`default_nettype wire

/* design/rgbgrad_locate.sv */
// ----------------------------------------------------------------------------
// RGB565 gradient segment locator
// Two pipeline stages: the first scales the clamped axis position by the
// segment count, the second finds the segment and offset and fetches the
// two bounding stops.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbgrad_locate #(
  parameter int DEN_W     = 8,
  parameter int MAX_STOPS = rgbgrad_pkg::DEF_MAX_STOPS
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic [rgbgrad_pkg::COORD_W-1:0]                 pixel_x,
  input  logic [rgbgrad_pkg::COORD_W-1:0]                 pixel_y,
  input  rgbgrad_pkg::cfg_t                               cfg,
  input  logic [DEN_W-1:0]                                den,
  input  logic [MAX_STOPS-1:0][rgbgrad_pkg::COLOR_W-1:0]  stop_color,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic [rgbgrad_pkg::COLOR_W-1:0]                 a_color,
  output logic [rgbgrad_pkg::COLOR_W-1:0]                 b_color,
  output logic [DEN_W-1:0]                                t
);

  localparam int COORD_W = rgbgrad_pkg::COORD_W;
  localparam int NUM_W   = rgbgrad_pkg::NUM_W;
  localparam int SEG_W   = rgbgrad_pkg::SEG_W;
  localparam int POS_W   = (COORD_W > DEN_W) ? COORD_W : DEN_W;
  localparam int THR_W   = DEN_W + SEG_W;
  localparam int CMP_W   = (NUM_W > THR_W) ? NUM_W : THR_W;
  localparam int IDX_W   = $clog2(MAX_STOPS);

  logic               scale_valid;
  logic               scale_ready;
  logic               fetch_ready;
  logic [NUM_W-1:0]   numer;
  logic [NUM_W-1:0]   numer_next;
  logic [COORD_W-1:0] pos;
  logic [COORD_W-1:0] pos_clamped;
  logic [SEG_W-1:0]   seg;
  logic [SEG_W-1:0]   seg_up;
  logic [CMP_W-1:0]   base;
  logic [CMP_W-1:0]   thr;

  // Stage handshake: a stage takes new data when it is empty or drains.
  assign fetch_ready = !out_valid || out_ready;
  assign scale_ready = !scale_valid || fetch_ready;
  assign in_ready    = scale_ready;

  // Position along the chosen axis, saturated at the last position.
  always_comb begin
    pos = cfg.vertical ? pixel_y : pixel_x;
    if (POS_W'(pos) > POS_W'(den)) begin
      pos_clamped = COORD_W'(den);
    end else begin
      pos_clamped = pos;
    end
    numer_next = NUM_W'(pos_clamped) * NUM_W'(cfg.seg_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_valid <= 1'b0;
    end else if (scale_ready) begin
      scale_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scale_ready && in_valid) begin
      numer <= numer_next;
    end
  end

  // Segment search: the highest boundary at or below the scaled position,
  // capped at the last segment so the final pixel lands on the last stop.
  always_comb begin
    seg  = '0;
    base = '0;
    thr  = '0;
    for (int k = 1; k < MAX_STOPS; k++) begin
      thr = CMP_W'(den) * CMP_W'(k);
      if (SEG_W'(k) < cfg.seg_count && CMP_W'(numer) >= thr) begin
        seg  = SEG_W'(k);
        base = thr;
      end
    end
    seg_up = seg + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fetch_ready) begin
      out_valid <= scale_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_ready && scale_valid) begin
      a_color <= stop_color[seg[IDX_W-1:0]];
      b_color <= stop_color[seg_up[IDX_W-1:0]];
      t       <= DEN_W'(CMP_W'(numer) - base);
    end
  end

endmodule

`default_nettype wire

/* design/rgbgrad_mix.sv */
// ----------------------------------------------------------------------------
// RGB565 gradient channel mixer
// One pipeline stage forming the weighted sum of the two stops per channel,
// with the rounding term added, ready for division by the span less one.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbgrad_mix #(
  parameter int DEN_W = 8
) (
  input  logic                                                         clk,
  input  logic                                                         rst,
  input  logic                                                         in_valid,
  output logic                                                         in_ready,
  input  logic [rgbgrad_pkg::COLOR_W-1:0]                              a_color,
  input  logic [rgbgrad_pkg::COLOR_W-1:0]                              b_color,
  input  logic [DEN_W-1:0]                                             t,
  input  logic [DEN_W-1:0]                                             den,
  output logic                                                         out_valid,
  input  logic                                                         out_ready,
  output logic [rgbgrad_pkg::NUM_CHANS-1:0][DEN_W+rgbgrad_pkg::CHAN_W-1:0] sum
);

  localparam int SUM_W = DEN_W + rgbgrad_pkg::CHAN_W;

  rgbgrad_pkg::chans_t                              a_ch;
  rgbgrad_pkg::chans_t                              b_ch;
  logic [DEN_W-1:0]                                 w;
  logic [rgbgrad_pkg::NUM_CHANS-1:0][SUM_W-1:0]     sum_next;

  assign in_ready = !out_valid || out_ready;

  // a*(den-t) + b*t + den/2 for each channel; the total stays below 64*den.
  always_comb begin
    a_ch = rgbgrad_pkg::split565(a_color);
    b_ch = rgbgrad_pkg::split565(b_color);
    w    = den - t;
    for (int c = 0; c < rgbgrad_pkg::NUM_CHANS; c++) begin
      sum_next[c] = SUM_W'(a_ch[c]) * SUM_W'(w) + SUM_W'(b_ch[c]) * SUM_W'(t) +
                    SUM_W'(den >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

/* design/rgbgrad_divstep.sv */
// ----------------------------------------------------------------------------
// RGB565 gradient divider stage
// One pipeline stage of a restoring divider that resolves a fixed pair of
// quotient bits for all three channels against the span divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbgrad_divstep #(
  parameter int DEN_W  = 8,
  parameter int HI_BIT = rgbgrad_pkg::CHAN_W - 1
) (
  input  logic                                                              clk,
  input  logic                                                              rst,
  input  logic                                                              in_valid,
  output logic                                                              in_ready,
  input  logic [rgbgrad_pkg::NUM_CHANS-1:0][DEN_W+rgbgrad_pkg::CHAN_W-1:0]  rem_in,
  input  rgbgrad_pkg::chans_t                                               quo_in,
  input  logic [DEN_W-1:0]                                                  den,
  output logic                                                              out_valid,
  input  logic                                                              out_ready,
  output logic [rgbgrad_pkg::NUM_CHANS-1:0][DEN_W+rgbgrad_pkg::CHAN_W-1:0]  rem_out,
  output rgbgrad_pkg::chans_t                                               quo_out
);

  localparam int SUM_W = DEN_W + rgbgrad_pkg::CHAN_W;

  logic [rgbgrad_pkg::NUM_CHANS-1:0][SUM_W-1:0] rem_next;
  rgbgrad_pkg::chans_t                          quo_next;

  assign in_ready = !out_valid || out_ready;

  // Compare and subtract the shifted divisor, most significant bit first.
  always_comb begin
    logic [SUM_W-1:0] d;
    rem_next = rem_in;
    quo_next = quo_in;
    d        = '0;
    for (int c = 0; c < rgbgrad_pkg::NUM_CHANS; c++) begin
      for (int j = 0; j < rgbgrad_pkg::DIV_BITS; j++) begin
        d = SUM_W'(den) << (HI_BIT - j);
        if (rem_next[c] >= d) begin
          rem_next[c]              = rem_next[c] - d;
          quo_next[c][HI_BIT - j]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_out <= rem_next;
      quo_out <= quo_next;
    end
  end

endmodule

`default_nettype wire

/* design/rgb565_gradient_generator.sv */
// ----------------------------------------------------------------------------
// RGB565 gradient generator
// Returns one RGB565 colour of a multi-stop linear background gradient for
// each pixel coordinate, horizontal or vertical, with up to four stops.
//
//   Channel   Signals                              Carries
//   pixel     pixel_valid/pixel_ready              pixel_x, pixel_y
//   color     color_valid/color_ready              pixel_color
//   register  psel/penable/pwrite/pready/paddr     pwdata in, prdata out
//
// One pixel is taken per cycle while the output is not stalled; each colour
// passes through six register stages: two locate stages, one mix stage,
// three divider stages at two quotient bits each.
// Reset clears every stage valid bit and loads the registers with their
// defaults: all stops black, one stop, horizontal.
// A stall on the colour side holds the output register; the stages behind
// it keep filling bubbles before the pixel side is held off.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_gradient_generator #(
  parameter int DISPLAY_WIDTH  = rgbgrad_pkg::DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = rgbgrad_pkg::DEF_DISPLAY_HEIGHT,
  parameter int MAX_STOPS      = rgbgrad_pkg::DEF_MAX_STOPS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rgbgrad_pkg::ADDR_W-1:0]     paddr,
  input  logic [rgbgrad_pkg::DATA_W-1:0]     pwdata,
  output logic [rgbgrad_pkg::DATA_W-1:0]     prdata,
  output logic                               pready,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic [rgbgrad_pkg::COORD_W-1:0]    pixel_x,
  input  logic [rgbgrad_pkg::COORD_W-1:0]    pixel_y,
  output logic                               color_valid,
  input  logic                               color_ready,
  output logic [rgbgrad_pkg::COLOR_W-1:0]    pixel_color
);

  localparam int SPAN_MAX   = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ? DISPLAY_WIDTH
                                                               : DISPLAY_HEIGHT;
  localparam int DEN_W      = $clog2(SPAN_MAX);
  localparam int SUM_W      = DEN_W + rgbgrad_pkg::CHAN_W;
  localparam int NUM_CHANS  = rgbgrad_pkg::NUM_CHANS;
  localparam int DIV_STAGES = rgbgrad_pkg::DIV_STAGES;
  localparam logic [DEN_W-1:0] DEN_X = DEN_W'(DISPLAY_WIDTH - 1);
  localparam logic [DEN_W-1:0] DEN_Y = DEN_W'(DISPLAY_HEIGHT - 1);

  logic [MAX_STOPS-1:0][rgbgrad_pkg::COLOR_W-1:0] stop_color;
  rgbgrad_pkg::cfg_t                              cfg;
  logic [DEN_W-1:0]                               den;

  logic                                 loc_valid;
  logic                                 loc_ready;
  logic [rgbgrad_pkg::COLOR_W-1:0]      a_color;
  logic [rgbgrad_pkg::COLOR_W-1:0]      b_color;
  logic [DEN_W-1:0]                     t;

  logic [DIV_STAGES:0]                                    dv_valid;
  logic [DIV_STAGES:0]                                    dv_ready;
  logic [DIV_STAGES:0][NUM_CHANS-1:0][SUM_W-1:0]          dv_rem;
  rgbgrad_pkg::chans_t [DIV_STAGES:0]                     dv_quo;

  // Register bank.
  rgbgrad_regs #(
    .MAX_STOPS (MAX_STOPS)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .stop_color (stop_color),
    .cfg        (cfg)
  );

  // The divisor is the span of the selected axis less one.
  assign den = cfg.vertical ? DEN_Y : DEN_X;

  // Segment search and stop fetch.
  rgbgrad_locate #(
    .DEN_W     (DEN_W),
    .MAX_STOPS (MAX_STOPS)
  ) u_locate (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pixel_valid),
    .in_ready   (pixel_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .cfg        (cfg),
    .den        (den),
    .stop_color (stop_color),
    .out_valid  (loc_valid),
    .out_ready  (loc_ready),
    .a_color    (a_color),
    .b_color    (b_color),
    .t          (t)
  );

  // Weighted channel sums.
  rgbgrad_mix #(
    .DEN_W (DEN_W)
  ) u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (loc_valid),
    .in_ready  (loc_ready),
    .a_color   (a_color),
    .b_color   (b_color),
    .t         (t),
    .den       (den),
    .out_valid (dv_valid[0]),
    .out_ready (dv_ready[0]),
    .sum       (dv_rem[0])
  );

  assign dv_quo[0] = '0;

  // Divider chain, two quotient bits per stage.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    rgbgrad_divstep #(
      .DEN_W  (DEN_W),
      .HI_BIT (rgbgrad_pkg::CHAN_W - 1 - s * rgbgrad_pkg::DIV_BITS)
    ) u_divstep (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[s]),
      .in_ready  (dv_ready[s]),
      .rem_in    (dv_rem[s]),
      .quo_in    (dv_quo[s]),
      .den       (den),
      .out_valid (dv_valid[s+1]),
      .out_ready (dv_ready[s+1]),
      .rem_out   (dv_rem[s+1]),
      .quo_out   (dv_quo[s+1])
    );
  end

  // The last divider stage is the output register.
  assign color_valid          = dv_valid[DIV_STAGES];
  assign dv_ready[DIV_STAGES] = color_ready;
  assign pixel_color          = rgbgrad_pkg::join565(dv_quo[DIV_STAGES]);

endmodule

`default_nettype wire

/* design/rgbgrad_checker.sv */
// ----------------------------------------------------------------------------
// RGB565 gradient port checker
// Watches the pixel and colour channels of the generator and checks reset,
// output holding and the count of pixels in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbgrad_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            pixel_valid,
  input logic                            pixel_ready,
  input logic                            color_valid,
  input logic                            color_ready,
  input logic [rgbgrad_pkg::COLOR_W-1:0] pixel_color
);

  localparam int CNT_W = $clog2(rgbgrad_pkg::PIPE_DEPTH + 1) + 1;

  logic [CNT_W-1:0] in_flight;
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = pixel_valid && pixel_ready;
  assign out_xfer = color_valid && color_ready;

  // Pixels taken but whose colour has not yet been transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + CNT_W'(in_xfer) - CNT_W'(out_xfer);
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !color_valid)
    else $error("colour valid right after reset");

  // A stalled colour stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color_ready |=> color_valid && $stable(pixel_color))
    else $error("stalled colour dropped or changed");

  // No colour without a pixel behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    color_valid |-> in_flight != '0)
    else $error("colour offered with no pixel in flight");

  // The pipeline never holds more pixels than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CNT_W'(rgbgrad_pkg::PIPE_DEPTH))
    else $error("more pixels in flight than pipeline stages");

  // An empty pipeline always takes a pixel.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    in_flight == '0 |-> pixel_ready)
    else $error("empty pipeline refused a pixel");

endmodule

bind rgb565_gradient_generator rgbgrad_checker u_rgbgrad_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_ready (pixel_ready),
  .color_valid (color_valid),
  .color_ready (color_ready),
  .pixel_color (pixel_color)
);

`default_nettype wire

/* sim/rgb565_gradient_generator_tb.sv */
// ----------------------------------------------------------------------------
// RGB565 gradient generator testbench
// Programs the stop bank, the stop count and the direction through the
// register port. It then streams pixel coordinates into the block and checks
// every returned colour against a predictor that is kept in step with the
// register writes. A directed opening covers segment boundaries, the last
// position, coordinates beyond the display and stop counts out of range.
// Randomised phases follow, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb565_gradient_generator_tb;

  // Widths, layout and register indexes taken from the package.
  localparam int COORD_W = rgbgrad_pkg::COORD_W;
  localparam int COLOR_W = rgbgrad_pkg::COLOR_W;
  localparam int ADDR_W = rgbgrad_pkg::ADDR_W;
  localparam int DATA_W = rgbgrad_pkg::DATA_W;
  localparam int REG_IDX_W = rgbgrad_pkg::REG_IDX_W;
  localparam int NSTOPS_W = rgbgrad_pkg::NSTOPS_W;
  localparam int NUM_STOP_REGS = rgbgrad_pkg::NUM_STOP_REGS;
  localparam int RB_W = rgbgrad_pkg::RB_W;
  localparam int G_W = rgbgrad_pkg::G_W;
  localparam int RED_LSB = rgbgrad_pkg::RED_LSB;
  localparam int GREEN_LSB = rgbgrad_pkg::GREEN_LSB;
  localparam int BLUE_LSB = rgbgrad_pkg::BLUE_LSB;
  localparam int DEF_MAX_STOPS = rgbgrad_pkg::DEF_MAX_STOPS;
  localparam int DEF_DISPLAY_WIDTH = rgbgrad_pkg::DEF_DISPLAY_WIDTH;
  localparam int DEF_DISPLAY_HEIGHT = rgbgrad_pkg::DEF_DISPLAY_HEIGHT;
  localparam int PIPE_DEPTH = rgbgrad_pkg::PIPE_DEPTH;
  localparam logic [REG_IDX_W-1:0] REG_NUM_STOPS = rgbgrad_pkg::REG_NUM_STOPS;
  localparam logic [REG_IDX_W-1:0] REG_VERTICAL = rgbgrad_pkg::REG_VERTICAL;

  localparam int PHASE_ITEMS = 50;
  localparam int RAND_PHASES = 17;
  localparam int QUIET_PHASES = 3;
  localparam int LONG_STALL = 48;
  localparam int TIMEOUT_NS = 2_000_000;

  localparam logic [REG_IDX_W-1:0] REG_STOP_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  // Colour predictor and store of expected colours, in transfer order.
  class gradient_scoreboard;
    logic [COLOR_W-1:0] stop_colour [NUM_STOP_REGS];
    logic [NSTOPS_W-1:0] stop_count;
    logic vertical;
    logic [COLOR_W-1:0] expected_colours [$];
    int unsigned failures;

    function new();
      foreach (stop_colour[i]) stop_colour[i] = '0;
      stop_count = NSTOPS_W'(1);
      vertical = 1'b0;
      failures = 0;
    endfunction

    // Mirror a register write; indexes past the list are dropped.
    function void update_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      if (idx < NUM_STOP_REGS) begin
        stop_colour[idx] = value[COLOR_W-1:0];
      end else if (idx == REG_NUM_STOPS) begin
        stop_count = value[NSTOPS_W-1:0];
      end else if (idx == REG_VERTICAL) begin
        vertical = value[0];
      end
    endfunction

    // Round-to-nearest blend of one channel between two stops.
    function int unsigned mix_channel(int unsigned a, int unsigned b, int unsigned t,
                                      int unsigned den);
      return (a * (den - t) + b * t + den / 2) / den;
    endfunction

    function logic [COLOR_W-1:0] predict_colour(logic [COORD_W-1:0] x,
                                                logic [COORD_W-1:0] y);
      int unsigned n, den, p, segs, numer, seg, t, r, g, b;
      logic [COLOR_W-1:0] c0, c1;
      n = stop_count;
      if (n < 1) n = 1;
      if (n > DEF_MAX_STOPS) n = DEF_MAX_STOPS;
      if (n == 1) begin
        return stop_colour[0];
      end
      den = vertical ? DEF_DISPLAY_HEIGHT - 1 : DEF_DISPLAY_WIDTH - 1;
      p = vertical ? y : x;
      // Positions past the display saturate at the last one.
      if (p > den) p = den;
      segs = n - 1;
      numer = p * segs;
      seg = numer / den;
      // The last position stays in the final segment at full offset.
      if (seg >= segs) seg = segs - 1;
      t = numer - seg * den;
      c0 = stop_colour[seg];
      c1 = stop_colour[seg + 1];
      r = mix_channel(c0[RED_LSB +: RB_W], c1[RED_LSB +: RB_W], t, den);
      g = mix_channel(c0[GREEN_LSB +: G_W], c1[GREEN_LSB +: G_W], t, den);
      b = mix_channel(c0[BLUE_LSB +: RB_W], c1[BLUE_LSB +: RB_W], t, den);
      return {RB_W'(r), G_W'(g), RB_W'(b)};
    endfunction

    function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      expected_colours.push_back(predict_colour(x, y));
    endfunction

    function void check_colour(logic [COLOR_W-1:0] actual);
      logic [COLOR_W-1:0] want;
      if (expected_colours.size() == 0) begin
        failures++;
        $error("pixel_color: transfer with no colour expected, actual %h", actual);
      end else begin
        want = expected_colours.pop_front();
        if (actual !== want) begin
          failures++;
          $error("pixel_color: expected %h, actual %h", want, actual);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_colours.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic pixel_valid;
  logic pixel_ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic color_valid;
  logic color_ready;
  logic [COLOR_W-1:0] pixel_color;

  gradient_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic hold_colour = 1'b0;

  rgb565_gradient_generator uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .color_valid (color_valid),
    .color_ready (color_ready),
    .pixel_color (pixel_color)
  );

  // Clock generation.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register write: a setup cycle, an access cycle, then the bus goes idle.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.update_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program the whole register set; unused upper data bits carry noise.
  task automatic set_gradient(input logic [COLOR_W-1:0] c0, input logic [COLOR_W-1:0] c1,
                              input logic [COLOR_W-1:0] c2, input logic [COLOR_W-1:0] c3,
                              input logic [NSTOPS_W-1:0] n, input logic vert);
    logic [COLOR_W-1:0] stops [NUM_STOP_REGS];
    stops = '{c0, c1, c2, c3};
    foreach (stops[i]) begin
      apb_write(REG_IDX_W'(REG_STOP_0 + i),
                ($urandom() & 32'hFFFF_0000) | DATA_W'(stops[i]));
    end
    apb_write(REG_NUM_STOPS, ($urandom() & ~32'h7) | DATA_W'(n));
    apb_write(REG_VERTICAL, ($urandom() & ~32'h1) | DATA_W'(vert));
  endtask

  // Offer one pixel, hold it until the transfer, then maybe leave a gap.
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    pixel_valid <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    do @(posedge clk); while (!pixel_ready);
    sb.note_pixel(x, y);
    if ($urandom_range(1, 100) <= send_idle_pct) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Stop offering pixels until every expected colour has come back.
  task automatic drain();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Stops lean towards black and white so the channel extremes come up often.
  function automatic logic [COLOR_W-1:0] random_stop();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return COLOR_W'($urandom());
  endfunction

  // Colour side: random stalls, and one long hold-off on request.
  initial begin
    color_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_colour) begin
        hold_colour = 1'b0;
        color_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if ($urandom_range(1, 100) <= recv_idle_pct) begin
        color_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      color_ready <= 1'b1;
    end
  end

  // Check every colour transfer.
  always @(posedge clk) begin
    if (!rst && color_valid && color_ready) begin
      sb.check_colour(pixel_color);
    end
  end

  // Stimulus.
  initial begin
    logic [COORD_W-1:0] h_points [10];
    logic [COORD_W-1:0] v_points [8];
    logic [NSTOPS_W-1:0] n;
    int phase;
    logic quiet;

    sb = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pixel_valid <= 1'b0;
    pixel_x <= '0;
    pixel_y <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults after reset: one black stop, flat everywhere.
    send_pixel('0, '0);
    send_pixel('1, '1);
    drain();

    // Four stops across the columns: segment edges, last column and beyond.
    h_points = '{8'd0, 8'd1, 8'd79, 8'd80, 8'd159, 8'd160, 8'd238, 8'd239, 8'd240, 8'd255};
    set_gradient(16'hFFFF, 16'h0000, 16'hF800, 16'h07E0, NSTOPS_W'(4), 1'b0);
    foreach (h_points[i]) send_pixel(h_points[i], COORD_W'($urandom()));
    drain();

    // The same stops down the rows, with rows past the display.
    v_points = '{8'd0, 8'd44, 8'd45, 8'd89, 8'd90, 8'd134, 8'd135, 8'd255};
    apb_write(REG_VERTICAL, DATA_W'(1));
    foreach (v_points[i]) send_pixel(COORD_W'($urandom()), v_points[i]);
    drain();

    // A zero stop count acts as one stop; writes past the list change nothing.
    apb_write(REG_NUM_STOPS, DATA_W'(0));
    apb_write(REG_UNMAPPED_LO, '1);
    apb_write(REG_UNMAPPED_HI, '1);
    send_pixel(8'd100, 8'd60);
    drain();

    // Counts above the bank size clamp to four; then two and three stops.
    set_gradient(16'h001F, 16'hFFE0, 16'h0000, 16'hFFFF, NSTOPS_W'(7), 1'b0);
    send_pixel(8'd120, 8'd0);
    drain();
    apb_write(REG_NUM_STOPS, DATA_W'(2));
    send_pixel(8'd1, 8'd0);
    drain();
    apb_write(REG_NUM_STOPS, DATA_W'(3));
    apb_write(REG_VERTICAL, DATA_W'(1));
    send_pixel(8'd0, 8'd67);
    drain();

    // Random phases; the closing ones run without any idling.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      quiet = (phase >= RAND_PHASES - QUIET_PHASES);
      send_idle_pct = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      recv_idle_pct = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      n = ($urandom_range(0, 9) < 6) ? NSTOPS_W'($urandom_range(2, 4))
                                     : NSTOPS_W'($urandom_range(0, 7));
      set_gradient(random_stop(), random_stop(), random_stop(), random_stop(), n,
                   1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) begin
        apb_write($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, $urandom());
      end
      // Once, stall the colour side for long while pixels keep coming.
      if (phase == 2) begin
        send_idle_pct = 0;
        hold_colour = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        send_pixel(($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 255))
                                               : COORD_W'($urandom_range(0, 239)),
                   ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 255))
                                               : COORD_W'($urandom_range(0, 134)));
      end
      drain();
    end

    // Let any stray colour show up before the verdict.
    repeat (PIPE_DEPTH * 4) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("** rgb565_gradient_generator: PASSED **");
    end else begin
      $display("** rgb565_gradient_generator: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("** rgb565_gradient_generator: FAILED **");
    $finish;
  end

endmodule
